// File: hw/rtl/euler_pose_to_transform_defines.svh
// Assertion macros used by the port-level checker file.
`ifndef EULER_POSE_TO_TRANSFORM_DEFINES_SVH
`define EULER_POSE_TO_TRANSFORM_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define EPOSE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Invariant checked on every clock edge outside reset.
`define EPOSE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

// File: hw/rtl/epose_pkg.sv
// Shared constants for the pose to transform pipeline.
package epose_pkg;

  localparam int ATAN_ENTRIES = 24;
  localparam int ZW = 34;

  localparam longint GAIN_Q30    = 64'd652032874;
  localparam longint PI_Q30      = 64'd3373259426;
  localparam longint HALF_PI_Q30 = 64'd1686629713;

  typedef logic [30:0] atan_t;

  localparam atan_t ATAN_Q30 [ATAN_ENTRIES] = '{
    31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158, 31'd67021686,
    31'd33543515,  31'd16775850,  31'd8388437,   31'd4194282,   31'd2097149,
    31'd1048575,   31'd524287,    31'd262143,    31'd131071,    31'd65535,
    31'd32767,     31'd16383,     31'd8191,      31'd4095,      31'd2047,
    31'd1023,      31'd511,       31'd255,       31'd127
  };

endpackage

// File: hw/rtl/epose_cell.sv
// One CORDIC rotation stage for one angle.
module epose_cell #(
  parameter int W     = 18,
  parameter int SHIFT = 0
) (
  input  logic                          clk,
  input  logic signed [W-1:0]           x_i,
  input  logic signed [W-1:0]           y_i,
  input  logic signed [epose_pkg::ZW-1:0] z_i,
  input  logic                          flip_i,
  output logic signed [W-1:0]           x_o,
  output logic signed [W-1:0]           y_o,
  output logic signed [epose_pkg::ZW-1:0] z_o,
  output logic                          flip_o
);

  localparam logic signed [epose_pkg::ZW-1:0] ATAN =
    epose_pkg::ZW'(epose_pkg::ATAN_Q30[SHIFT]);

  logic signed [W-1:0] x_nxt, y_nxt, x_r, y_r;
  logic signed [epose_pkg::ZW-1:0] z_nxt, z_r;
  logic flip_r;

  always_comb begin
    if (!z_i[epose_pkg::ZW-1]) begin
      x_nxt = x_i - (y_i >>> SHIFT);
      y_nxt = y_i + (x_i >>> SHIFT);
      z_nxt = z_i - ATAN;
    end else begin
      x_nxt = x_i + (y_i >>> SHIFT);
      y_nxt = y_i - (x_i >>> SHIFT);
      z_nxt = z_i + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    flip_r <= flip_i;
  end

  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;
  assign flip_o = flip_r;

endmodule

// File: hw/rtl/epose_mat.sv
// Three-stage matrix product Qz*Qy*Qx with Q1.15 rounding and saturation.
module epose_mat #(
  parameter int W = 18,
  parameter int F = 15
) (
  input  logic                 clk,
  input  logic signed [W-1:0]  sx_i, cx_i, sy_i, cy_i, sz_i, cz_i,
  input  logic                 fx_i, fy_i, fz_i,
  output logic signed [15:0]   r00_o, r01_o, r02_o,
  output logic signed [15:0]   r10_o, r11_o, r12_o,
  output logic signed [15:0]   r20_o, r21_o, r22_o
);

  localparam int DN = (F > 15) ? F - 15 : 0;
  localparam int UP = (F < 15) ? 15 - F : 0;
  localparam int RW = W + 2 + UP;
  localparam logic signed [RW-1:0] RND = (F > 15) ? (RW'(1) <<< (F - 16)) : '0;

  function automatic logic signed [W-1:0] fmul(input logic signed [W-1:0] a,
                                              input logic signed [W-1:0] b);
    logic signed [2*W-1:0] p;
    p = a * b;
    p = p + ((2*W)'(1) <<< (F - 1));
    fmul = W'(p >>> F);
  endfunction

  function automatic logic signed [15:0] q15(input logic signed [W:0] v);
    logic signed [RW-1:0] r;
    r = RW'(v);
    r = ((r + RND) >>> DN) <<< UP;
    if (r > RW'(32767)) q15 = 16'sd32767;
    else if (r < -RW'(32768)) q15 = -16'sd32768;
    else q15 = 16'(r);
  endfunction

  function automatic logic signed [W:0] add(input logic signed [W-1:0] a,
                                            input logic signed [W-1:0] b);
    add = (W+1)'(a) + (W+1)'(b);
  endfunction

  logic signed [W-1:0] sx, cx, sy, cy, sz, cz;
  // stage 1: pair products
  logic signed [W-1:0] czcy_r, szcx_r, szsx_r, szcy_r, czcx_r, czsx_r;
  logic signed [W-1:0] cysx_r, cycx_r, czsy_r, szsy_r, sx_r, cx_r, sy_r;
  // stage 2: triple products
  logic signed [W-1:0] t1_r, t2_r, t3_r, t4_r;
  logic signed [W-1:0] czcy2_r, szcx2_r, szsx2_r, szcy2_r, czcx2_r, czsx2_r;
  logic signed [W-1:0] cysx2_r, cycx2_r, sy2_r;
  logic signed [15:0] r_r [9];

  // fold the half-turn correction back in
  assign sx = fx_i ? -sx_i : sx_i;
  assign cx = fx_i ? -cx_i : cx_i;
  assign sy = fy_i ? -sy_i : sy_i;
  assign cy = fy_i ? -cy_i : cy_i;
  assign sz = fz_i ? -sz_i : sz_i;
  assign cz = fz_i ? -cz_i : cz_i;

  always_ff @(posedge clk) begin
    czcy_r <= fmul(cz, cy);
    szcx_r <= fmul(sz, cx);
    szsx_r <= fmul(sz, sx);
    szcy_r <= fmul(sz, cy);
    czcx_r <= fmul(cz, cx);
    czsx_r <= fmul(cz, sx);
    cysx_r <= fmul(cy, sx);
    cycx_r <= fmul(cy, cx);
    czsy_r <= fmul(cz, sy);
    szsy_r <= fmul(sz, sy);
    sx_r   <= sx;
    cx_r   <= cx;
    sy_r   <= sy;

    t1_r    <= fmul(czsy_r, sx_r);
    t2_r    <= fmul(czsy_r, cx_r);
    t3_r    <= fmul(szsy_r, sx_r);
    t4_r    <= fmul(szsy_r, cx_r);
    czcy2_r <= czcy_r;
    szcx2_r <= szcx_r;
    szsx2_r <= szsx_r;
    szcy2_r <= szcy_r;
    czcx2_r <= czcx_r;
    czsx2_r <= czsx_r;
    cysx2_r <= cysx_r;
    cycx2_r <= cycx_r;
    sy2_r   <= sy_r;

    r_r[0] <= q15((W+1)'(czcy2_r));
    r_r[1] <= q15(add(szcx2_r, t1_r));
    r_r[2] <= q15(add(szsx2_r, -t2_r));
    r_r[3] <= q15(-(W+1)'(szcy2_r));
    r_r[4] <= q15(add(czcx2_r, -t3_r));
    r_r[5] <= q15(add(czsx2_r, t4_r));
    r_r[6] <= q15((W+1)'(sy2_r));
    r_r[7] <= q15(-(W+1)'(cysx2_r));
    r_r[8] <= q15((W+1)'(cycx2_r));
  end

  assign r00_o = r_r[0];
  assign r01_o = r_r[1];
  assign r02_o = r_r[2];
  assign r10_o = r_r[3];
  assign r11_o = r_r[4];
  assign r12_o = r_r[5];
  assign r20_o = r_r[6];
  assign r21_o = r_r[7];
  assign r22_o = r_r[8];

endmodule

// File: hw/rtl/euler_pose_to_transform.sv
// Top level: pose (translation plus roll, pitch, yaw) to 3x4 rigid transform.
//
// Fully pipelined: one request is taken every cycle and busy never rises.
// Each request yields one result, registered through the angle range fold,
// the N = min(CORDIC_STAGES, 24) CORDIC cells of each rotator chain, and the
// matrix product stages (pair products, triple products, sum with rounding).
// The result shows for one cycle with out_valid high; the receiver cannot stall
// it, so take it then.
module euler_pose_to_transform #(
  parameter int CORDIC_STAGES = 16,
  parameter int FRAC_BITS     = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_trans_x,
  input  logic signed [31:0] in_trans_y,
  input  logic signed [31:0] in_trans_z,
  input  logic signed [15:0] in_roll,
  input  logic signed [15:0] in_pitch,
  input  logic signed [15:0] in_yaw,
  output logic               out_valid,
  output logic signed [15:0] out_r00,
  output logic signed [15:0] out_r01,
  output logic signed [15:0] out_r02,
  output logic signed [15:0] out_r10,
  output logic signed [15:0] out_r11,
  output logic signed [15:0] out_r12,
  output logic signed [15:0] out_r20,
  output logic signed [15:0] out_r21,
  output logic signed [15:0] out_r22,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z
);

  localparam int ZW = epose_pkg::ZW;
  // Stages past the arctangent table do not run.
  localparam int N = (CORDIC_STAGES < epose_pkg::ATAN_ENTRIES) ?
                     CORDIC_STAGES : epose_pkg::ATAN_ENTRIES;
  localparam int W = FRAC_BITS + 3;
  localparam int LATENCY = N + 4;
  localparam longint K0 =
    (((epose_pkg::GAIN_Q30 * 2) >>> (30 - FRAC_BITS)) + 1) >>> 1;
  localparam logic signed [W-1:0] X0 = W'(K0);
  localparam logic signed [ZW-1:0] HALF_PI = ZW'(epose_pkg::HALF_PI_Q30);
  localparam logic signed [ZW-1:0] PI = ZW'(epose_pkg::PI_Q30);

  logic signed [ZW-1:0] za [3];
  logic signed [ZW-1:0] z_r [3];
  logic                 f_r [3];
  logic signed [W-1:0]  xc [3][N+1];
  logic signed [W-1:0]  yc [3][N+1];
  logic signed [ZW-1:0] zc [3][N+1];
  logic                 fc [3][N+1];

  logic [LATENCY-1:0] v_r, v_nxt;
  logic signed [31:0] tx_r [LATENCY];
  logic signed [31:0] ty_r [LATENCY];
  logic signed [31:0] tz_r [LATENCY];

  assign busy = 1'b0;

  // Widen Q3.13 angles to Q30.
  assign za[0] = {in_roll[15], in_roll, 17'b0};
  assign za[1] = {in_pitch[15], in_pitch, 17'b0};
  assign za[2] = {in_yaw[15], in_yaw, 17'b0};

  // Fold angles beyond a quarter turn back by a half turn; flip signs later.
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      if (za[a] > HALF_PI) begin
        z_r[a] <= za[a] - PI;
        f_r[a] <= 1'b1;
      end else if (za[a] < -HALF_PI) begin
        z_r[a] <= za[a] + PI;
        f_r[a] <= 1'b1;
      end else begin
        z_r[a] <= za[a];
        f_r[a] <= 1'b0;
      end
    end
  end

  // Three parallel rotator chains, one cell per micro-rotation.
  for (genvar a = 0; a < 3; a++) begin : g_ang
    assign xc[a][0] = X0;
    assign yc[a][0] = '0;
    assign zc[a][0] = z_r[a];
    assign fc[a][0] = f_r[a];
    for (genvar s = 0; s < N; s++) begin : g_stg
      epose_cell #(.W(W), .SHIFT(s)) u_cell (
        .clk    (clk),
        .x_i    (xc[a][s]),
        .y_i    (yc[a][s]),
        .z_i    (zc[a][s]),
        .flip_i (fc[a][s]),
        .x_o    (xc[a][s+1]),
        .y_o    (yc[a][s+1]),
        .z_o    (zc[a][s+1]),
        .flip_o (fc[a][s+1])
      );
    end
  end

  epose_mat #(.W(W), .F(FRAC_BITS)) u_mat (
    .clk   (clk),
    .sx_i  (yc[0][N]), .cx_i (xc[0][N]),
    .sy_i  (yc[1][N]), .cy_i (xc[1][N]),
    .sz_i  (yc[2][N]), .cz_i (xc[2][N]),
    .fx_i  (fc[0][N]), .fy_i (fc[1][N]), .fz_i (fc[2][N]),
    .r00_o (out_r00), .r01_o (out_r01), .r02_o (out_r02),
    .r10_o (out_r10), .r11_o (out_r11), .r12_o (out_r12),
    .r20_o (out_r20), .r21_o (out_r21), .r22_o (out_r22)
  );

  // Advance the request marker and the translation alongside the datapath.
  assign v_nxt = {v_r[LATENCY-2:0], start};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tx_r[0] <= in_trans_x;
    ty_r[0] <= in_trans_y;
    tz_r[0] <= in_trans_z;
    for (int i = 1; i < LATENCY; i++) begin
      tx_r[i] <= tx_r[i-1];
      ty_r[i] <= ty_r[i-1];
      tz_r[i] <= tz_r[i-1];
    end
  end

  assign out_valid = v_r[LATENCY-1];
  assign out_x     = tx_r[LATENCY-1];
  assign out_y     = ty_r[LATENCY-1];
  assign out_z     = tz_r[LATENCY-1];

endmodule

// File: hw/rtl/epose_chk.sv
// Port-level checker for the pose to transform block, with its bind.
`include "euler_pose_to_transform_defines.svh"

module epose_chk #(
  parameter int LAT = 20
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic signed [31:0] in_trans_x,
  input logic signed [31:0] in_trans_z,
  input logic               out_valid,
  input logic signed [31:0] out_x,
  input logic signed [31:0] out_z
);

  `EPOSE_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")
  `EPOSE_ASSERT_IMPL(a_valid_has_request, out_valid, $past(start, LAT), "result without request")
  `EPOSE_ASSERT_IMPL(a_x_passes, out_valid, out_x == $past(in_trans_x, LAT), "out_x mismatch")
  `EPOSE_ASSERT_IMPL(a_z_passes, out_valid, out_z == $past(in_trans_z, LAT), "out_z mismatch")

endmodule

bind euler_pose_to_transform epose_chk #(.LAT(LATENCY)) u_epose_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_trans_x (in_trans_x),
  .in_trans_z (in_trans_z),
  .out_valid  (out_valid),
  .out_x      (out_x),
  .out_z      (out_z)
);
